@@ rtl/stkb_pkg.sv @@
// Package for the scancode to key bytes block: codes, key tables and shared types.
package stkb_pkg;

    localparam int NUM_TERMINALS = 8;
    localparam int MAX_BYTES     = 4;

    localparam logic [7:0] SC_EXT_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_CTRL_DOWN   = 8'h1D;
    localparam logic [7:0] SC_CTRL_UP     = 8'h9D;
    localparam logic [7:0] SC_ALT_DOWN    = 8'h38;
    localparam logic [7:0] SC_ALT_UP      = 8'hB8;
    localparam logic [7:0] SC_LSHIFT_DOWN = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_DOWN = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
    localparam logic [7:0] SC_CAPS        = 8'h3A;
    localparam logic [7:0] SC_NUMLOCK     = 8'h45;
    localparam logic [7:0] SC_F1          = 8'h3B;
    localparam logic [7:0] SC_F8          = 8'h42;
    localparam logic [7:0] SC_TABLE_LEN   = 8'h3A;

    localparam logic [7:0] SC_KP_ENTER    = 8'h1C;
    localparam logic [7:0] SC_KP_SLASH    = 8'h35;
    localparam logic [7:0] SC_UP          = 8'h48;
    localparam logic [7:0] SC_DOWN        = 8'h50;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_HOME        = 8'h47;
    localparam logic [7:0] SC_END         = 8'h4F;
    localparam logic [7:0] SC_PGUP        = 8'h49;
    localparam logic [7:0] SC_PGDN        = 8'h51;
    localparam logic [7:0] SC_DELETE      = 8'h53;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_CASE    = 8'h20;
    localparam logic [7:0] CH_CTRL    = 8'h40;

    typedef struct packed {
        logic [2:0]                count;
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic                      is_switch;
        logic [2:0]                target;
    } key_seq_t;

    function automatic logic [7:0] plain_char(input logic [5:0] code);
        logic [7:0] c;
        case (code)
            6'd1:  c = 8'h1B;  6'd2:  c = 8'h31;  6'd3:  c = 8'h32;  6'd4:  c = 8'h33;
            6'd5:  c = 8'h34;  6'd6:  c = 8'h35;  6'd7:  c = 8'h36;  6'd8:  c = 8'h37;
            6'd9:  c = 8'h38;  6'd10: c = 8'h39;  6'd11: c = 8'h30;  6'd12: c = 8'h2D;
            6'd13: c = 8'h3D;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h71;
            6'd17: c = 8'h77;  6'd18: c = 8'h65;  6'd19: c = 8'h72;  6'd20: c = 8'h74;
            6'd21: c = 8'h79;  6'd22: c = 8'h75;  6'd23: c = 8'h69;  6'd24: c = 8'h6F;
            6'd25: c = 8'h70;  6'd26: c = 8'h5B;  6'd27: c = 8'h5D;  6'd28: c = 8'h0A;
            6'd30: c = 8'h61;  6'd31: c = 8'h73;  6'd32: c = 8'h64;  6'd33: c = 8'h66;
            6'd34: c = 8'h67;  6'd35: c = 8'h68;  6'd36: c = 8'h6A;  6'd37: c = 8'h6B;
            6'd38: c = 8'h6C;  6'd39: c = 8'h3B;  6'd40: c = 8'h27;  6'd41: c = 8'h60;
            6'd43: c = 8'h5C;  6'd44: c = 8'h7A;  6'd45: c = 8'h78;  6'd46: c = 8'h63;
            6'd47: c = 8'h76;  6'd48: c = 8'h62;  6'd49: c = 8'h6E;  6'd50: c = 8'h6D;
            6'd51: c = 8'h2C;  6'd52: c = 8'h2E;  6'd53: c = 8'h2F;  6'd57: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // shifted symbol for non-letter keys; keys without one keep the plain char
    function automatic logic [7:0] shift_char(input logic [5:0] code, input logic [7:0] plain);
        logic [7:0] c;
        case (code)
            6'd2:  c = 8'h21;  6'd3:  c = 8'h40;  6'd4:  c = 8'h23;  6'd5:  c = 8'h24;
            6'd6:  c = 8'h25;  6'd7:  c = 8'h5E;  6'd8:  c = 8'h26;  6'd9:  c = 8'h2A;
            6'd10: c = 8'h28;  6'd11: c = 8'h29;  6'd12: c = 8'h5F;  6'd13: c = 8'h2B;
            6'd26: c = 8'h7B;  6'd27: c = 8'h7D;  6'd39: c = 8'h3A;  6'd40: c = 8'h22;
            6'd41: c = 8'h7E;  6'd43: c = 8'h7C;  6'd51: c = 8'h3C;  6'd52: c = 8'h3E;
            6'd53: c = 8'h3F;
            default: c = plain;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] map_key(input logic [5:0] code, input logic shift,
                                           input logic caps);
        logic [7:0] p;
        logic [7:0] c;
        logic       letter;
        p      = plain_char(code);
        letter = (p >= 8'h61) && (p <= 8'h7A);
        if (letter)
            c = (shift ^ caps) ? (p - CH_CASE) : p;
        else
            c = shift ? shift_char(code, p) : p;
        return c;
    endfunction

endpackage

@@ rtl/stkb_decode.sv @@
// Key state registers and single-pass decode of one scancode into a byte sequence.
module stkb_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           code,
    input  logic                 take,
    input  logic                 app_mode,
    output stkb_pkg::key_seq_t   seq
);

    logic       ext_reg, ctrl_reg, alt_reg, shift_reg, caps_reg;
    logic       ext_next, ctrl_next, alt_next, shift_next, caps_next;
    logic [2:0] term_reg, term_next;
    logic [7:0] target_wide;
    logic [7:0] ch;
    logic [7:0] cursor_mid;
    logic       ext_hit;

    assign target_wide = code - stkb_pkg::SC_F1;
    assign cursor_mid  = app_mode ? stkb_pkg::CH_O : stkb_pkg::CH_LBRACK;

    always_comb
    begin
        ch = stkb_pkg::map_key(code[5:0], shift_reg, caps_reg);
        if (ctrl_reg)
        begin
            if ((ch >= 8'h61) && (ch <= 8'h7A))
                ch = ch - stkb_pkg::CH_CASE;
            ch = ch - stkb_pkg::CH_CTRL;
        end
    end

    always_comb
    begin
        ext_next   = 1'b0;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        shift_next = shift_reg;
        caps_next  = caps_reg;
        term_next  = term_reg;
        seq        = '0;
        ext_hit    = 1'b0;

        if (code == stkb_pkg::SC_EXT_PREFIX)
        begin
            ext_next = 1'b1;
            ext_hit  = 1'b1;
        end
        else if (ext_reg)
        begin
            ext_hit = 1'b1;
            case (code)
                stkb_pkg::SC_CTRL_DOWN: ctrl_next = 1'b1;
                stkb_pkg::SC_CTRL_UP:   ctrl_next = 1'b0;
                stkb_pkg::SC_KP_ENTER:
                begin
                    seq.count    = 3'd1;
                    seq.bytes[0] = stkb_pkg::CH_LF;
                end
                stkb_pkg::SC_KP_SLASH:
                begin
                    seq.count    = 3'd1;
                    seq.bytes[0] = stkb_pkg::CH_SLASH;
                end
                stkb_pkg::SC_UP, stkb_pkg::SC_DOWN, stkb_pkg::SC_RIGHT, stkb_pkg::SC_LEFT:
                begin
                    seq.count    = 3'd3;
                    seq.bytes[0] = stkb_pkg::CH_ESC;
                    seq.bytes[1] = cursor_mid;
                    case (code)
                        stkb_pkg::SC_UP:    seq.bytes[2] = 8'h41;
                        stkb_pkg::SC_DOWN:  seq.bytes[2] = 8'h42;
                        stkb_pkg::SC_RIGHT: seq.bytes[2] = 8'h43;
                        default:            seq.bytes[2] = 8'h44;
                    endcase
                end
                stkb_pkg::SC_HOME, stkb_pkg::SC_END, stkb_pkg::SC_PGUP, stkb_pkg::SC_PGDN,
                stkb_pkg::SC_DELETE:
                begin
                    seq.count    = 3'd4;
                    seq.bytes[0] = stkb_pkg::CH_ESC;
                    seq.bytes[1] = stkb_pkg::CH_LBRACK;
                    seq.bytes[3] = stkb_pkg::CH_TILDE;
                    case (code)
                        stkb_pkg::SC_HOME: seq.bytes[2] = 8'h31;
                        stkb_pkg::SC_END:  seq.bytes[2] = 8'h34;
                        stkb_pkg::SC_PGUP: seq.bytes[2] = 8'h35;
                        stkb_pkg::SC_PGDN: seq.bytes[2] = 8'h36;
                        default:           seq.bytes[2] = 8'h33;
                    endcase
                end
                default: ext_hit = 1'b0;
            endcase
        end

        if (!ext_hit)
        begin
            case (code)
                stkb_pkg::SC_NUMLOCK: ;
                stkb_pkg::SC_ALT_DOWN:  alt_next = 1'b1;
                stkb_pkg::SC_ALT_UP:    alt_next = 1'b0;
                stkb_pkg::SC_LSHIFT_DOWN, stkb_pkg::SC_RSHIFT_DOWN: shift_next = 1'b1;
                stkb_pkg::SC_LSHIFT_UP, stkb_pkg::SC_RSHIFT_UP:     shift_next = 1'b0;
                stkb_pkg::SC_CTRL_DOWN: ctrl_next = 1'b1;
                stkb_pkg::SC_CTRL_UP:   ctrl_next = 1'b0;
                stkb_pkg::SC_CAPS:      caps_next = !caps_reg;
                default:
                begin
                    if (alt_reg)
                    begin
                        if ((code >= stkb_pkg::SC_F1) && (code <= stkb_pkg::SC_F8)
                            && (target_wide < 8'(stkb_pkg::NUM_TERMINALS))
                            && (target_wide[2:0] != term_reg))
                        begin
                            term_next     = target_wide[2:0];
                            seq.count     = 3'd1;
                            seq.is_switch = 1'b1;
                            seq.target    = target_wide[2:0];
                        end
                    end
                    else if (code < stkb_pkg::SC_TABLE_LEN)
                    begin
                        seq.count    = 3'd1;
                        seq.bytes[0] = ch;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg   <= 1'b0;
            ctrl_reg  <= 1'b0;
            alt_reg   <= 1'b0;
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            term_reg  <= '0;
        end
        else if (take)
        begin
            ext_reg   <= ext_next;
            ctrl_reg  <= ctrl_next;
            alt_reg   <= alt_next;
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            term_reg  <= term_next;
        end
    end

endmodule

@@ rtl/stkb_emit.sv @@
// Output sequencer: holds one decoded sequence and sends its bytes one per cycle while ready is high.
module stkb_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  stkb_pkg::key_seq_t seq,
    output logic               can_load,
    output logic               valid,
    input  logic               ready,
    output logic [7:0]         out_byte,
    output logic               is_switch,
    output logic [2:0]         switch_target,
    output logic               last
);

    logic                               busy_reg;
    logic [2:0]                         cnt_reg;
    logic [1:0]                         idx_reg;
    logic [stkb_pkg::MAX_BYTES-1:0][7:0] bytes_reg;
    logic                               sw_reg;
    logic [2:0]                         tgt_reg;
    logic                               fire;

    assign valid         = busy_reg;
    assign last          = ({1'b0, idx_reg} == (cnt_reg - 3'd1));
    assign fire          = busy_reg && ready;
    assign can_load      = !busy_reg || (fire && last);
    assign out_byte      = bytes_reg[idx_reg];
    assign is_switch     = sw_reg;
    assign switch_target = tgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (load && (seq.count != 3'd0))
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cnt_reg  <= seq.count;
        end
        else if (fire)
        begin
            if (last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && (seq.count != 3'd0))
        begin
            bytes_reg <= seq.bytes;
            sw_reg    <= seq.is_switch;
            tgt_reg   <= seq.target;
        end
    end

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 3'd0) && (cnt_reg <= 3'd4))
        else $error("active sequence with bad length");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("byte index past sequence end");
    a_switch_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && sw_reg) |-> (cnt_reg == 3'd1) && (bytes_reg[0] == 8'h00))
        else $error("switch result not a single zero-byte item");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last && !load) |=> busy_reg && (idx_reg == $past(idx_reg) + 2'd1))
        else $error("sequence did not advance after transfer");

endmodule

@@ rtl/scancode_to_key_bytes_core.sv @@
// Top level: scancode input register, decode with key state, byte sequencer.
//
//  channel  | signals                           | payload
//  ---------+-----------------------------------+-------------------------------------
//  s_       | s_tvalid s_tready s_tdata[7:0]    | scancode
//  m_       | m_tvalid m_tready m_tdata m_tuser | out_byte, switch_target; is_switch
//           | m_tlast                           | last byte of this scancode
//  cfg_     | cfg_valid cfg_ready cfg_data      | cursor_key_app_mode
//
//  A scancode is registered on transfer and decoded from that register once the
//  sequencer can load it; its bytes then leave one per cycle while m_tready is high
//  through the single output port. A scancode with no result sends no byte.
//  Reset clears key state, the mode register and both valid flags.
//  A stalled m_ side holds the current byte; one scancode waits in the input register.
module scancode_to_key_bytes_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [10:8] switch_target, [15:11] zero
    output logic        m_tuser,    // [0] is_switch
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         code_reg;
    logic               mode_reg;
    logic               can_load;
    logic               take;
    stkb_pkg::key_seq_t seq;
    logic [7:0]         out_byte;
    logic [2:0]         switch_target;

    assign take      = in_valid_reg && can_load;
    assign s_tready  = !in_valid_reg || can_load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (take)
                in_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            code_reg <= s_tdata;
    end

    stkb_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .code     (code_reg),
        .take     (take),
        .app_mode (mode_reg),
        .seq      (seq)
    );

    stkb_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take),
        .seq           (seq),
        .can_load      (can_load),
        .valid         (m_tvalid),
        .ready         (m_tready),
        .out_byte      (out_byte),
        .is_switch     (m_tuser),
        .switch_target (switch_target),
        .last          (m_tlast)
    );

    assign m_tdata = {5'b0, switch_target, out_byte};

endmodule
